@@ design/console_cpu_bus_decoder_top_defines.svh @@
// Assertion macros shared by the checker of the console CPU bus decoder.
`ifndef CONSOLE_CPU_BUS_DECODER_TOP_DEFINES_SVH
`define CONSOLE_CPU_BUS_DECODER_TOP_DEFINES_SVH

// The antecedent implies the consequent in the same cycle, outside of reset.
`define CCBD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// The antecedent implies the consequent in the next cycle, outside of reset.
`define CCBD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

@@ design/ccbd_pkg.sv @@
// Types and constants shared by the console CPU bus decoder modules.
package ccbd_pkg;

	localparam int BANK_COUNT = 8;
	localparam int BANK_W     = 3;

	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 72;

	typedef enum logic [1:0] {
		OP_RD_BYTE = 2'd0,
		OP_RD_WORD = 2'd1,
		OP_WR_BYTE = 2'd2,
		OP_WR_WORD = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		TGT_LOCAL    = 4'd0,
		TGT_ROM      = 4'd1,
		TGT_VDP_DATA = 4'd2,
		TGT_VDP_CTRL = 4'd3,
		TGT_VDP_HV   = 4'd4,
		TGT_PSG      = 4'd5,
		TGT_COPROC   = 4'd6,
		TGT_PAD_DATA = 4'd7,
		TGT_PAD_CTRL = 4'd8
	} target_t;

	typedef enum logic [1:0] {
		LANE_WORD = 2'd0,
		LANE_HIGH = 2'd1,
		LANE_LOW  = 2'd2,
		LANE_DUP  = 2'd3
	} lane_t;

	// Memory map constants.
	localparam logic [23:0] VDP_MASK     = 24'hE700E0;
	localparam logic [23:0] VDP_BASE     = 24'hC00000;
	localparam logic [23:0] BANK_SEL_MSK = 24'h380000;
	localparam logic [23:0] BANK_OFF_MSK = 24'h07FFFF;
	localparam logic [15:0] IO_VERSION   = 16'hA0A0;
	localparam logic [23:0] BUSREQ_ADDR  = 24'hA11100;
	localparam logic [23:0] ZRESET_ADDR  = 24'hA11200;
	localparam logic [15:0] ZWIN_MASK    = 16'h7FFF;
	localparam logic [23:0] RAM_BASE     = 24'hE00000;
	localparam logic [23:0] ROM_END      = 24'h400000;
	localparam logic [23:0] BANK_FIRST   = 24'hA130F3;
	localparam logic [23:0] IO_BASE      = 24'hA10000;
	localparam logic [7:0]  ZWIN_PAGE    = 8'hA0;

	typedef struct packed {
		op_t         op;
		logic [23:0] address;
		logic [15:0] write_data;
	} req_t;

	typedef struct packed {
		logic        unhandled;
		logic        coproc_reset_pulse;
		lane_t       lane_mode;
		logic [15:0] read_data;
		logic [15:0] out_data;
		logic [26:0] target_offset;
		target_t     target;
	} rsp_t;

	typedef struct packed {
		logic              ram_we;
		logic [15:0]       ram_wdata;
		logic              bus_req_we;
		logic              running_we;
		logic              flag_val;
		logic              bank_we;
		logic [BANK_W-1:0] bank_sel;
		logic [7:0]        bank_val;
	} upd_t;

endpackage

@@ design/console_cpu_bus_decoder_top.sv @@
// Top level of the console CPU bus decoder: stream ports, pipeline and state.
//
// The decoder takes one byte or word CPU access per transfer on the slave
// stream and returns exactly one decoded result per access on the master
// stream, in order. It accepts a new access every clock cycle unless the
// master stream holds it back; an access passes through the decode stage
// register and then the output register before its result is offered. The
// rate rests on the single work RAM: the word an access needs is read at the
// transfer edge, the decode stage forms the result, and as a RAM write leaves
// it the modified word is written back, so a read and a write share the RAM
// together. When an access reads the word that its predecessor writes at
// that same edge, the written value is forwarded from a holding register. The
// output register parts the two sides, so a finished result that waits for
// m_axis_tready does not stop the next access from entering the decode stage.
// Bank registers and the co-processor flags are updated when an access leaves
// the decode stage, so the next access always sees them up to date. The work
// RAM has no reset; a RAM word must be written before it is read. The
// cart_banked register is to be written over the cfg channel only while no
// access is in flight, not enforced by the block; cfg_ready is always high.
module console_cpu_bus_decoder_top #(
	parameter int RAM_WORDS = 32768
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// operation[1:0], address[25:2], write_data[41:26], zero fill above
	input  logic [ccbd_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// target[3:0], target_offset[30:4], out_data[46:31], read_data[62:47],
	// lane_mode[64:63], coproc_reset_pulse[65], unhandled[66], zero fill above
	output logic [ccbd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic                               cfg_data
);
	import ccbd_pkg::*;

	localparam int AW = $clog2(RAM_WORDS);

	req_t                        in_req;
	logic                        accept;
	logic                        adv;
	logic [19:0]                 rem;
	logic [AW-1:0]               in_idx;
	logic                        ram_we;
	logic [15:0]                 ram_rdata;
	logic [15:0]                 word_s1;
	rsp_t                        rsp;
	upd_t                        upd;

	logic                        valid_s1;
	req_t                        req_s1;
	logic [AW-1:0]               idx_s1;
	logic                        fwd_hit_s1;
	logic [15:0]                 fwd_data_s1;

	logic                        out_valid_q;
	logic [OUT_TDATA_W-1:0]      out_data_q;
	logic                        cart_banked_q;
	logic [BANK_COUNT-1:0][7:0]  bank_q;
	logic                        bus_req_q;
	logic                        running_q;

	assign in_req.op         = op_t'(s_axis_tdata[1:0]);
	assign in_req.address    = s_axis_tdata[25:2];
	assign in_req.write_data = s_axis_tdata[41:26];

	// The word index wraps at the RAM depth. The quotient stays below 32 for
	// any depth of 1024 words or more, so five conditional subtractions settle it.
	always_comb begin
		rem = {5'd0, in_req.address[15:1]};
		for (int k = 4; k >= 0; k--) begin
			if (rem >= (20'(RAM_WORDS) << k)) begin
				rem = rem - (20'(RAM_WORDS) << k);
			end
		end
		in_idx = rem[AW-1:0];
	end

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign adv           = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;
	assign ram_we        = adv && upd.ram_we;
	assign word_s1       = fwd_hit_s1 ? fwd_data_s1 : ram_rdata;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	ccbd_ram #(
		.DEPTH (RAM_WORDS),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_s1),
		.wdata (upd.ram_wdata),
		.re    (accept),
		.raddr (in_idx),
		.rdata (ram_rdata)
	);

	ccbd_decode u_decode (
		.req         (req_s1),
		.ram_word    (word_s1),
		.cart_banked (cart_banked_q),
		.bank_regs   (bank_q),
		.bus_req     (bus_req_q),
		.running     (running_q),
		.rsp         (rsp),
		.upd         (upd)
	);

	// Decode stage payload and the forwarding register for a same-edge write.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1      <= in_req;
			idx_s1      <= in_idx;
			fwd_hit_s1  <= ram_we && (idx_s1 == in_idx);
			fwd_data_s1 <= upd.ram_wdata;
		end
		if (adv) begin
			out_data_q <= {5'd0, rsp};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// State registers: cart_banked from cfg, the rest as an access leaves decode.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cart_banked_q <= 1'b0;
			bus_req_q     <= 1'b0;
			running_q     <= 1'b0;
			for (int i = 0; i < BANK_COUNT; i++) begin
				bank_q[i] <= 8'(i);
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				cart_banked_q <= cfg_data;
			end
			if (adv && upd.bus_req_we) begin
				bus_req_q <= upd.flag_val;
			end
			if (adv && upd.running_we) begin
				running_q <= upd.flag_val;
			end
			if (adv && upd.bank_we) begin
				bank_q[upd.bank_sel] <= upd.bank_val;
			end
		end
	end

endmodule

@@ design/ccbd_ram.sv @@
// Single-port-write, registered-read work RAM of the bus decoder.
module ccbd_ram #(
	parameter int DEPTH = 32768,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [15:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [15:0]   rdata
);

	logic [15:0] mem [DEPTH];

	// Read returns the old contents when both ports hit the same word.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ design/ccbd_decode.sv @@
// Address decode and state update logic for one bus access.
module ccbd_decode (
	input  ccbd_pkg::req_t                            req,
	input  logic [15:0]                               ram_word,
	input  logic                                      cart_banked,
	input  logic [ccbd_pkg::BANK_COUNT-1:0][7:0]      bank_regs,
	input  logic                                      bus_req,
	input  logic                                      running,
	output ccbd_pkg::rsp_t                            rsp,
	output ccbd_pkg::upd_t                            upd
);
	import ccbd_pkg::*;

	logic        wr;
	logic        word;
	logic [23:0] a;
	logic [4:0]  lo;
	logic [15:0] v;
	logic        owned;
	logic [26:0] rom_off;
	logic        vdp_hit;
	logic        flag_bit;

	always_comb begin
		wr       = (req.op == OP_WR_BYTE) || (req.op == OP_WR_WORD);
		word     = (req.op == OP_RD_WORD) || (req.op == OP_WR_WORD);
		a        = req.address;
		lo       = a[4:0];
		v        = word ? req.write_data : {8'h00, req.write_data[7:0]};
		owned    = running && bus_req;
		vdp_hit  = (a & VDP_MASK) == VDP_BASE;
		flag_bit = word ? v[8] : v[0];
		rom_off  = cart_banked ? {bank_regs[a[21:19]], a[18:0]} : {3'b000, a};

		rsp = '0;
		upd = '0;
		upd.ram_wdata = ram_word;
		upd.flag_val  = flag_bit;
		upd.bank_sel  = a[3:1];
		upd.bank_val  = v[7:0];

		if (!wr) begin
			rsp.read_data = word ? 16'hFFFF : 16'h00FF;
			if (a < ROM_END) begin
				rsp.target        = TGT_ROM;
				rsp.target_offset = {rom_off[26:1], rom_off[0] && !word};
				if (word) begin
					rsp.lane_mode = LANE_WORD;
				end else begin
					rsp.lane_mode = rom_off[0] ? LANE_LOW : LANE_HIGH;
				end
			end else if (a >= RAM_BASE) begin
				if (word) begin
					rsp.read_data = ram_word;
				end else begin
					rsp.read_data = {8'h00, a[0] ? ram_word[7:0] : ram_word[15:8]};
				end
			end else if (a >= VDP_BASE) begin
				if (vdp_hit && !lo[4] && !(word && lo[0])) begin
					if (lo < 5'd4) begin
						rsp.target = TGT_VDP_DATA;
					end else if (lo < 5'd8) begin
						rsp.target = TGT_VDP_CTRL;
					end else begin
						rsp.target = TGT_VDP_HV;
					end
					if (word) begin
						rsp.lane_mode = LANE_WORD;
					end else begin
						rsp.lane_mode = lo[0] ? LANE_LOW : LANE_HIGH;
					end
				end
			end else if (a[23:16] == ZWIN_PAGE) begin
				if (owned) begin
					rsp.target        = TGT_COPROC;
					rsp.target_offset = {12'd0, a[14:0] & ZWIN_MASK[14:0]};
					rsp.lane_mode     = word ? LANE_DUP : LANE_LOW;
				end
			end else if (a[23:5] == IO_BASE[23:5]) begin
				if (!(word && lo[0])) begin
					if (lo[4:1] == 4'd0) begin
						rsp.read_data = word ? IO_VERSION : {8'h00, IO_VERSION[7:0]};
					end else if (lo[4:1] <= 4'd3) begin
						rsp.target        = TGT_PAD_DATA;
						rsp.target_offset = {25'd0, 2'(lo[2:1] - 2'd1)};
						rsp.lane_mode     = word ? LANE_DUP : LANE_LOW;
					end else if (lo[4:1] <= 4'd6) begin
						rsp.target        = TGT_PAD_CTRL;
						rsp.target_offset = {25'd0, lo[2:1]};
						rsp.lane_mode     = word ? LANE_DUP : LANE_LOW;
					end else if (!(lo[4:1] == 4'd7 || lo[4:1] == 4'd10 || lo[4:1] == 4'd13)) begin
						rsp.read_data = 16'h0000;
					end
				end
			end else if (a == BUSREQ_ADDR) begin
				rsp.read_data = word ? {7'd0, !owned, 8'h00} : {15'd0, !owned};
			end else if (a == ZRESET_ADDR) begin
				rsp.read_data = word ? {7'd0, running, 8'h00} : {15'd0, running};
			end else begin
				rsp.unhandled = 1'b1;
			end
			if (rsp.target != TGT_LOCAL) begin
				rsp.read_data = 16'h0000;
			end
		end else begin
			if (a >= RAM_BASE) begin
				upd.ram_we = 1'b1;
				if (word) begin
					upd.ram_wdata = v;
				end else if (a[0]) begin
					upd.ram_wdata = {ram_word[15:8], v[7:0]};
				end else begin
					upd.ram_wdata = {v[7:0], ram_word[7:0]};
				end
			end else if (a >= VDP_BASE) begin
				if (vdp_hit) begin
					if (!word) begin
						if (lo < 5'd4) begin
							rsp.target   = TGT_VDP_DATA;
							rsp.out_data = {v[7:0], v[7:0]};
						end else if (lo < 5'd8) begin
							rsp.target   = TGT_VDP_CTRL;
							rsp.out_data = {v[7:0], v[7:0]};
						end else if (lo[4:3] == 2'b10 && lo[0]) begin
							rsp.target   = TGT_PSG;
							rsp.out_data = v;
						end
					end else if (!lo[0]) begin
						if (lo < 5'd4) begin
							rsp.target   = TGT_VDP_DATA;
							rsp.out_data = v;
						end else if (lo < 5'd8) begin
							rsp.target   = TGT_VDP_CTRL;
							rsp.out_data = v;
						end else if (lo[4:3] == 2'b10) begin
							rsp.target   = TGT_PSG;
							rsp.out_data = {8'h00, v[7:0]};
						end
					end
				end
			end else if (a[23:16] == ZWIN_PAGE) begin
				if (owned) begin
					rsp.target        = TGT_COPROC;
					rsp.target_offset = {12'd0, a[14:0] & ZWIN_MASK[14:0]};
					rsp.out_data      = word ? {8'h00, v[15:8]} : v;
				end
			end else if (a[23:5] == IO_BASE[23:5]) begin
				if (!word) begin
					if (lo >= 5'd2 && lo <= 5'd7) begin
						rsp.target        = TGT_PAD_DATA;
						rsp.target_offset = {25'd0, 2'(lo[2:1] - 2'd1)};
						rsp.out_data      = v;
					end else if (lo >= 5'd8 && lo <= 5'd13) begin
						rsp.target        = TGT_PAD_CTRL;
						rsp.target_offset = {25'd0, lo[2:1]};
						rsp.out_data      = v;
					end
				end
			end else if (a == BUSREQ_ADDR) begin
				upd.bus_req_we = 1'b1;
			end else if (a == ZRESET_ADDR) begin
				upd.running_we             = 1'b1;
				rsp.coproc_reset_pulse     = flag_bit && !bus_req;
			end else if (a[23:4] == BANK_FIRST[23:4] && a[3:1] != 3'd0 && (a[0] == !word)) begin
				if (cart_banked) begin
					upd.bank_we = 1'b1;
				end else begin
					rsp.unhandled = 1'b1;
				end
			end else begin
				rsp.unhandled = 1'b1;
			end
		end
	end

endmodule

@@ design/ccbd_checker.sv @@
// Port-level checks for the console CPU bus decoder, bound to the top level.
`include "console_cpu_bus_decoder_top_defines.svh"

module ccbd_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [ccbd_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import ccbd_pkg::*;

	// A result that is not taken stays offered unchanged.
	`CCBD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata))

	// External targets never carry a locally answered read value.
	`CCBD_ASSERT_IMP(a_ext_no_rdata, m_axis_tvalid && (m_axis_tdata[3:0] != TGT_LOCAL),
		m_axis_tdata[62:47] == 16'h0000)

	// An unmapped access is never sent to a target and has no lane mode.
	`CCBD_ASSERT_IMP(a_unh_local, m_axis_tvalid && m_axis_tdata[66],
		(m_axis_tdata[3:0] == TGT_LOCAL) && (m_axis_tdata[64:63] == LANE_WORD))

	// A co-processor reset pulse comes only from a mapped local flag write.
	`CCBD_ASSERT_IMP(a_pulse_local, m_axis_tvalid && m_axis_tdata[65],
		(m_axis_tdata[3:0] == TGT_LOCAL) && !m_axis_tdata[66] && (m_axis_tdata[62:47] == 16'h0000))

endmodule

bind console_cpu_bus_decoder_top ccbd_checker u_ccbd_checker (.*);

@@ sim/ccbd_result_checker.sv @@
// Scoreboard of the console CPU bus decoder: predicts each access and checks each result.
`timescale 1ns / 100ps

module ccbd_result_checker
	import ccbd_pkg::*;
#(
	parameter int RAM_WORDS = 32768
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic                   cfg_data,
	output int                     mismatches,
	output int                     pending,
	output int                     results_checked,
	output int                     coproc_hits,
	output int                     reset_pulses,
	output int                     unhandled_hits
);

	localparam int RSP_W = $bits(rsp_t);

	bit [15:0]  ram_image [RAM_WORDS];
	logic [7:0] bank_map [BANK_COUNT];
	bit         bus_requested;
	bit         z_running;
	bit         banked_mode;
	rsp_t       expected_q [$];

	// Decodes one access against the shadow state and applies its side effects.
	function automatic rsp_t decode_access(req_t acc);
		rsp_t        res;
		logic [23:0] a;
		logic [4:0]  lo;
		logic [4:0]  e;
		logic [15:0] v;
		logic [15:0] w;
		logic [26:0] off;
		bit          wr;
		bit          wide;
		bit          owned;
		bit          flag;
		int          idx;

		res   = '0;
		a     = acc.address;
		lo    = a[4:0];
		wr    = acc.op[1];
		wide  = acc.op[0];
		idx   = int'(a[15:1]) % RAM_WORDS;
		owned = z_running && bus_requested;
		if (!wr) begin
			res.read_data = wide ? 16'hFFFF : 16'h00FF;
			if (a < ROM_END) begin
				res.target = TGT_ROM;
				off = banked_mode ? {bank_map[a[21:19]], a[18:0]} : {3'b000, a};
				if (wide) begin
					off[0] = 1'b0;
					res.lane_mode = LANE_WORD;
				end else begin
					res.lane_mode = off[0] ? LANE_LOW : LANE_HIGH;
				end
				res.target_offset = off;
			end else if (a >= RAM_BASE) begin
				w = ram_image[idx];
				res.read_data = wide ? w : (a[0] ? {8'h00, w[7:0]} : {8'h00, w[15:8]});
			end else if (a >= VDP_BASE) begin
				if ((a & VDP_MASK) == VDP_BASE && lo < 5'd16 && !(wide && lo[0])) begin
					res.target = (lo < 5'd4) ? TGT_VDP_DATA :
						((lo < 5'd8) ? TGT_VDP_CTRL : TGT_VDP_HV);
					res.lane_mode = wide ? LANE_WORD : (lo[0] ? LANE_LOW : LANE_HIGH);
				end
			end else if (a[23:16] == ZWIN_PAGE) begin
				if (owned) begin
					res.target = TGT_COPROC;
					res.target_offset = 27'(a[15:0] & ZWIN_MASK);
					res.lane_mode = wide ? LANE_DUP : LANE_LOW;
				end
			end else if (a[23:5] == IO_BASE[23:5]) begin
				if (!(wide && lo[0])) begin
					e = lo & 5'h1E;
					if (e == 5'h00) begin
						res.read_data = wide ? IO_VERSION : {8'h00, IO_VERSION[7:0]};
					end else if (e <= 5'h06) begin
						res.target = TGT_PAD_DATA;
						res.target_offset = 27'((e - 5'd2) >> 1);
						res.lane_mode = wide ? LANE_DUP : LANE_LOW;
					end else if (e <= 5'h0C) begin
						res.target = TGT_PAD_CTRL;
						res.target_offset = 27'((e - 5'd8) >> 1);
						res.lane_mode = wide ? LANE_DUP : LANE_LOW;
					end else if (e == 5'h0E || e == 5'h14 || e == 5'h1A) begin
						res.read_data = wide ? 16'hFFFF : 16'h00FF;
					end else begin
						res.read_data = 16'h0000;
					end
				end
			end else if (a == BUSREQ_ADDR) begin
				res.read_data = wide ? {7'd0, !owned, 8'h00} : {15'd0, !owned};
			end else if (a == ZRESET_ADDR) begin
				res.read_data = wide ? {7'd0, z_running, 8'h00} : {15'd0, z_running};
			end else begin
				res.unhandled = 1'b1;
			end
			if (res.target != TGT_LOCAL)
				res.read_data = 16'h0000;
		end else begin
			v    = wide ? acc.write_data : {8'h00, acc.write_data[7:0]};
			flag = wide ? v[8] : v[0];
			if (a >= RAM_BASE) begin
				if (wide)
					ram_image[idx] = v;
				else if (a[0])
					ram_image[idx][7:0] = v[7:0];
				else
					ram_image[idx][15:8] = v[7:0];
			end else if (a >= VDP_BASE) begin
				if ((a & VDP_MASK) == VDP_BASE) begin
					if (!wide) begin
						if (lo < 5'd4) begin
							res.target = TGT_VDP_DATA;
							res.out_data = {v[7:0], v[7:0]};
						end else if (lo < 5'd8) begin
							res.target = TGT_VDP_CTRL;
							res.out_data = {v[7:0], v[7:0]};
						end else if (lo == 5'h11 || lo == 5'h13 || lo == 5'h15 || lo == 5'h17) begin
							res.target = TGT_PSG;
							res.out_data = v;
						end
					end else if (!lo[0]) begin
						if (lo < 5'd4) begin
							res.target = TGT_VDP_DATA;
							res.out_data = v;
						end else if (lo < 5'd8) begin
							res.target = TGT_VDP_CTRL;
							res.out_data = v;
						end else if (lo >= 5'h10 && lo <= 5'h16) begin
							res.target = TGT_PSG;
							res.out_data = {8'h00, v[7:0]};
						end
					end
				end
			end else if (a[23:16] == ZWIN_PAGE) begin
				if (owned) begin
					res.target = TGT_COPROC;
					res.target_offset = 27'(a[15:0] & ZWIN_MASK);
					res.out_data = wide ? {8'h00, v[15:8]} : v;
				end
			end else if (a[23:5] == IO_BASE[23:5]) begin
				// Word writes to the pad ports are dropped.
				if (!wide) begin
					if (lo >= 5'h02 && lo <= 5'h07) begin
						res.target = TGT_PAD_DATA;
						res.target_offset = 27'((lo - 5'd2) >> 1);
						res.out_data = v;
					end else if (lo >= 5'h08 && lo <= 5'h0D) begin
						res.target = TGT_PAD_CTRL;
						res.target_offset = 27'((lo - 5'd8) >> 1);
						res.out_data = v;
					end
				end
			end else if (a == BUSREQ_ADDR) begin
				bus_requested = flag;
			end else if (a == ZRESET_ADDR) begin
				z_running = flag;
				if (z_running && !bus_requested)
					res.coproc_reset_pulse = 1'b1;
			end else if (a[23:4] == BANK_FIRST[23:4] && a[3:1] != 3'd0 && a[0] == !wide) begin
				// Odd bytes or even words in the bank window; bank 0 is never reached.
				if (banked_mode)
					bank_map[a[3:1]] = v[7:0];
				else
					res.unhandled = 1'b1;
			end else begin
				res.unhandled = 1'b1;
			end
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t got;
		rsp_t want;
		req_t acc;
		int   k;

		if (!arst_n) begin
			for (k = 0; k < BANK_COUNT; k++)
				bank_map[k] = 8'(k);
			bus_requested   = 1'b0;
			z_running       = 1'b0;
			banked_mode     = 1'b0;
			expected_q.delete();
			mismatches      = 0;
			pending         = 0;
			results_checked = 0;
			coproc_hits     = 0;
			reset_pulses    = 0;
			unhandled_hits  = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				banked_mode = cfg_data;
			// Results leave before the access of this edge is predicted.
			if (m_axis_tvalid && m_axis_tready) begin
				got = rsp_t'(m_axis_tdata[RSP_W-1:0]);
				if (expected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("checker: result %h arrived with nothing expected",
							m_axis_tdata);
				end else begin
					want = expected_q.pop_front();
					results_checked++;
					if (got !== want || m_axis_tdata[OUT_TDATA_W-1:RSP_W] !== '0) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"checker: result %0d (expected/actual) target %0d/%0d",
								" offset %h/%h out %h/%h read %h/%h lane %0d/%0d",
								" pulse %b/%b unhandled %b/%b fill %h"},
								results_checked, want.target, got.target,
								want.target_offset, got.target_offset,
								want.out_data, got.out_data, want.read_data, got.read_data,
								want.lane_mode, got.lane_mode,
								want.coproc_reset_pulse, got.coproc_reset_pulse,
								want.unhandled, got.unhandled,
								m_axis_tdata[OUT_TDATA_W-1:RSP_W]);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				acc.op         = op_t'(s_axis_tdata[1:0]);
				acc.address    = s_axis_tdata[25:2];
				acc.write_data = s_axis_tdata[41:26];
				want = decode_access(acc);
				if (want.target == TGT_COPROC)
					coproc_hits++;
				if (want.coproc_reset_pulse)
					reset_pulses++;
				if (want.unhandled)
					unhandled_hits++;
				expected_q.push_back(want);
			end
			pending = expected_q.size();
		end
	end

endmodule

@@ sim/tb_console_cpu_bus_decoder_top.sv @@
// Testbench top of the console CPU bus decoder: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_console_cpu_bus_decoder_top;
	import ccbd_pkg::*;

	localparam int RAM_WORDS       = 32768;
	localparam int RANDOM_ITEMS    = 1300;
	localparam int PHASES          = 5;
	// The slowest correct run stays far below this: every access waits at most
	// a sender gap, a receiver stall and the two pipeline stages.
	localparam int CYCLE_LIMIT     = 1000000;
	localparam int HOLD_OFF_CYCLES = 120;
	localparam int DRAIN_CYCLES    = 12;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	// operation[1:0], address[25:2], write_data[41:26], zero fill above
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// target[3:0], target_offset[30:4], out_data[46:31], read_data[62:47],
	// lane_mode[64:63], coproc_reset_pulse[65], unhandled[66], zero fill above
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic                   cfg_data = 1'b0;

	int mismatches;
	int pending;
	int results_checked;
	int coproc_hits;
	int reset_pulses;
	int unhandled_hits;

	int cycle_count   = 0;
	int accesses_sent = 0;
	int burst_left    = 0;
	bit hold_off_request = 1'b0;

	// Which bytes of each RAM word hold known data, and the words with both.
	bit hi_written [RAM_WORDS];
	bit lo_written [RAM_WORDS];
	int full_words [$];

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	console_cpu_bus_decoder_top #(
		.RAM_WORDS(RAM_WORDS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	ccbd_result_checker #(
		.RAM_WORDS(RAM_WORDS)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.mismatches     (mismatches),
		.pending        (pending),
		.results_checked(results_checked),
		.coproc_hits    (coproc_hits),
		.reset_pulses   (reset_pulses),
		.unhandled_hits (unhandled_hits)
	);

	// Offers one access and holds it until the transfer. A read of RAM bytes
	// that were never written is turned into a write of the same width, since
	// the work RAM has no reset value. After each burst the sender may pause.
	task automatic push_access(op_t op, logic [23:0] addr, logic [15:0] data);
		int idx;
		int gap;

		idx = int'(addr[15:1]) % RAM_WORDS;
		if (!op[1] && addr >= RAM_BASE) begin
			if ((op == OP_RD_WORD && !(hi_written[idx] && lo_written[idx])) ||
			    (op == OP_RD_BYTE && !(addr[0] ? lo_written[idx] : hi_written[idx])))
				op = op_t'({1'b1, op[0]});
		end
		if (op[1] && addr >= RAM_BASE && !(hi_written[idx] && lo_written[idx])) begin
			if (op == OP_WR_WORD || !addr[0])
				hi_written[idx] = 1'b1;
			if (op == OP_WR_WORD || addr[0])
				lo_written[idx] = 1'b1;
			if (hi_written[idx] && lo_written[idx])
				full_words.push_back(idx);
		end
		s_axis_tdata  <= {{(IN_TDATA_W - 42){1'b0}}, data, addr, op};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		accesses_sent++;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Writes the cartridge mapping mode once every result is back. Each access
	// gives exactly one result, so a few extra cycles cover the pipeline.
	task automatic write_cart_mode(bit banked);
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (3) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= banked;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// One random access, weighted toward the decoded regions. RAM reads go to
	// words that are known, often to the most recent ones so that a read meets
	// the write just before it in the pipeline.
	task automatic random_access();
		op_t         op;
		logic [23:0] a;
		logic [15:0] d;
		int          sel;
		int          idx;
		int          n;

		op  = op_t'($urandom_range(0, 3));
		d   = 16'($urandom);
		sel = $urandom_range(0, 99);
		n   = full_words.size();
		if (sel < 12) begin
			a = 24'($urandom_range(0, 24'h3FFFFF));
		end else if (sel < 34) begin
			if (n > 0 && (!op[1] || $urandom_range(0, 1) == 1)) begin
				if ($urandom_range(0, 1) == 1)
					idx = full_words[$urandom_range((n > 8) ? n - 8 : 0, n - 1)];
				else
					idx = full_words[$urandom_range(0, n - 1)];
			end else begin
				idx = $urandom_range(0, RAM_WORDS - 1);
			end
			a = {3'b111, 5'($urandom), 15'(idx), 1'($urandom)};
		end else if (sel < 50) begin
			// Mostly addresses that pass the VDP mask, some that miss it.
			if ($urandom_range(0, 4) != 0)
				a = {3'b110, 2'($urandom), 3'b000, 8'($urandom), 3'b000, 5'($urandom)};
			else
				a = {3'b110, 21'($urandom)};
		end else if (sel < 62) begin
			a = {ZWIN_PAGE, 16'($urandom)};
		end else if (sel < 74) begin
			a = {IO_BASE[23:5], 5'($urandom)};
		end else if (sel < 86) begin
			// Flag writes set the flag three times in four, so the window is
			// often owned and the reset pulse shows up.
			a = ($urandom_range(0, 1) == 1) ? BUSREQ_ADDR : ZRESET_ADDR;
			if ($urandom_range(0, 9) == 0)
				a = a + 24'($urandom_range(1, 3));
			d[8] = ($urandom_range(0, 3) != 0);
			d[0] = ($urandom_range(0, 3) != 0);
		end else if (sel < 93) begin
			a = {BANK_FIRST[23:4], 4'($urandom)};
		end else begin
			a = 24'($urandom);
		end
		push_access(op, a, d);
	endtask

	// The receiver runs through stretches of full readiness, random stalls and
	// a fixed pattern. On request it holds off for a long stretch, so that the
	// block fills up and stalls the sender.
	initial begin : result_sink
		int seg_kind;
		int seg_len;
		int i;

		wait (arst_n);
		forever begin
			if (hold_off_request) begin
				m_axis_tready <= 1'b0;
				for (i = 0; i < HOLD_OFF_CYCLES; i++)
					@(posedge clk);
				hold_off_request = 1'b0;
			end else begin
				seg_kind = $urandom_range(0, 3);
				seg_len  = $urandom_range(4, 60);
				for (i = 0; i < seg_len; i++) begin
					case (seg_kind)
						0: m_axis_tready <= 1'b1;
						1: m_axis_tready <= ($urandom_range(0, 1) == 1);
						2: m_axis_tready <= ($urandom_range(0, 3) == 0);
						default: m_axis_tready <= ((i % 3) != 2);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	// Cycle counter that ends a hung run.
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: run stopped after %0d cycles, %0d results still expected",
			cycle_count, pending);
		$display("tb: failure");
		$finish;
	end

	initial begin : stimulus
		int p;
		int n;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Flat mapping: every region, both widths, the odd-address word cases.
		write_cart_mode(1'b0);
		push_access(OP_WR_WORD, 24'hE00000, 16'h1234);
		push_access(OP_RD_BYTE, 24'hE00000, 16'h0000);
		push_access(OP_RD_BYTE, 24'hE00001, 16'h0000);
		push_access(OP_WR_BYTE, 24'hFFFFFE, 16'hFFA5);
		push_access(OP_WR_BYTE, 24'hFFFFFF, 16'h005A);
		push_access(OP_RD_WORD, 24'hFFFFFE, 16'h0000);
		push_access(OP_RD_BYTE, 24'h000000, 16'h0000);
		push_access(OP_RD_BYTE, 24'h3FFFFF, 16'h0000);
		push_access(OP_RD_WORD, 24'h3FFFFF, 16'h0000);
		push_access(OP_WR_WORD, 24'h000100, 16'hBEEF);
		push_access(OP_RD_WORD, 24'hC00000, 16'h0000);
		push_access(OP_WR_BYTE, 24'hC00005, 16'h1281);
		push_access(OP_RD_BYTE, 24'hC00009, 16'h0000);
		// Word read at an odd port and an address outside the VDP mask.
		push_access(OP_RD_WORD, 24'hC00001, 16'h0000);
		push_access(OP_RD_BYTE, 24'hC00020, 16'h0000);
		push_access(OP_WR_BYTE, 24'hC00011, 16'hFF9F);
		push_access(OP_WR_WORD, 24'hC00010, 16'hABCD);
		push_access(OP_WR_WORD, 24'hC00016, 16'h5A3C);
		push_access(OP_RD_BYTE, 24'hA10001, 16'h0000);
		push_access(OP_RD_WORD, 24'hA10000, 16'h0000);
		push_access(OP_RD_BYTE, 24'hA10003, 16'h0000);
		push_access(OP_WR_BYTE, 24'hA10009, 16'h0040);
		push_access(OP_WR_WORD, 24'hA10002, 16'h0040);
		push_access(OP_RD_BYTE, 24'hA1000E, 16'h0000);
		push_access(OP_RD_WORD, 24'hA10010, 16'h0000);
		// Co-processor window: not owned, then owned, then a reset pulse.
		push_access(OP_RD_BYTE, 24'hA00000, 16'h0000);
		push_access(OP_WR_WORD, BUSREQ_ADDR, 16'h0100);
		push_access(OP_WR_BYTE, ZRESET_ADDR, 16'h0001);
		push_access(OP_RD_WORD, 24'hA0FFFF & 24'hFFFFFE, 16'h0000);
		push_access(OP_WR_BYTE, 24'hA0FFFF, 16'h00C3);
		push_access(OP_RD_BYTE, BUSREQ_ADDR, 16'h0000);
		push_access(OP_WR_WORD, BUSREQ_ADDR, 16'h0000);
		push_access(OP_WR_BYTE, ZRESET_ADDR, 16'h0001);
		push_access(OP_RD_WORD, ZRESET_ADDR, 16'h0000);
		// A bank write while the mapping is flat, and a hole in the map.
		push_access(OP_WR_BYTE, 24'hA130F3, 16'h0005);
		push_access(OP_RD_WORD, 24'h800000, 16'h0000);

		// Banked mapping: the highest bank value and a mid value.
		write_cart_mode(1'b1);
		push_access(OP_WR_WORD, 24'hA130FE, 16'h12FF);
		push_access(OP_WR_BYTE, 24'hA130F3, 16'h0080);
		push_access(OP_RD_BYTE, 24'h380001, 16'h0000);
		push_access(OP_RD_WORD, 24'h0FFFFF, 16'h0000);
		push_access(OP_RD_BYTE, 24'h000000, 16'h0000);

		// Random phases alternate the mapping mode; two of them start with a
		// long receiver hold-off.
		for (p = 0; p < PHASES; p++) begin
			write_cart_mode((p % 2) == 0);
			if (p == 0 || p == 3)
				hold_off_request = 1'b1;
			for (n = 0; n < RANDOM_ITEMS / PHASES; n++)
				random_access();
		end

		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("tb: %0d accesses sent, %0d results checked, %0d mismatches",
			accesses_sent, results_checked, mismatches);
		$display("tb: flat and banked ROM, RAM, VDP, PSG and pads seen; %0d window hits, %0d %s",
			coproc_hits, reset_pulses, "reset pulses");
		if (mismatches == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

@@ console_cpu_bus_decoder_top.f @@
+incdir+design
design/ccbd_pkg.sv
design/ccbd_ram.sv
design/ccbd_decode.sv
design/console_cpu_bus_decoder_top.sv
design/ccbd_checker.sv
sim/ccbd_result_checker.sv
sim/tb_console_cpu_bus_decoder_top.sv
